### rtl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types and constants for the framed page extractor: byte codes of the
// frame header, phase encoding and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package fpe_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 14;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // header and terminator characters
  localparam logic [BYTE_W-1:0] CHR_M  = 8'h4D;
  localparam logic [BYTE_W-1:0] CHR_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_G  = 8'h67;
  localparam logic [BYTE_W-1:0] CHR_I  = 8'h69;
  localparam logic [BYTE_W-1:0] CHR_NL = 8'h0A;

  localparam logic [BYTE_W-1:0] FRAME_INDEX_RST = 8'd1;

  // controller phases
  typedef enum logic [3:0] {
    PH_H0       = 4'd0,
    PH_H1       = 4'd1,
    PH_H2       = 4'd2,
    PH_H3       = 4'd3,
    PH_TOTAL    = 4'd4,
    PH_PRE      = 4'd5,
    PH_CAP      = 4'd6,
    PH_POST     = 4'd7,
    PH_TERM     = 4'd8,
    PH_EMIT_RD  = 4'd9,
    PH_EMIT_LD  = 4'd10,
    PH_EMIT_OUT = 4'd11
  } phase_t;

  // byte counter operations
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_LOAD,
    CNT_DEC,
    CNT_INC
  } count_op_t;

  // controller -> datapath
  typedef struct packed {
    count_op_t count_op;
    logic      mul_post;    // multiplier operand: 1 = post skip, 0 = pre skip
    logic      load_total;
    logic      ram_we;
    logic      ram_re;
    logic      load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_m;
    logic is_a;
    logic is_g;
    logic is_i;
    logic is_nl;
    logic pre_nonzero;
    logic post_pos;
    logic count_one;
    logic count_last;
  } stat_t;

endpackage

### rtl/fpe_if.sv
// ----------------------------------------------------------------------------
// fpe_in_if / fpe_out_if
// Valid/ready channels for received bytes and for emitted page bytes.
// ----------------------------------------------------------------------------
interface fpe_in_if import fpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpe_out_if import fpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] page_byte;
  logic              last_byte;

  modport source (output valid, output page_byte, output last_byte, input ready);
  modport sink   (input valid, input page_byte, input last_byte, output ready);
endinterface

### rtl/framed_page_extractor_unit.sv
// ----------------------------------------------------------------------------
// framed_page_extractor_unit
// Extracts one page from a framed serial byte stream and replays it.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the block hunts for the
// "Magi" header, reads the frame count, skips, captures and checks the
// newline terminator; in all those phases every input item is accepted in
// the cycle it is offered. A matching terminator starts the page readout,
// during which input is held off: each of the PAGE_BYTES result items goes
// through a page store read, an output register load and presentation, plus
// any time the sink holds ready low. The last item carries last_byte.
// frame_index sits at byte address 0 of the APB port and is sampled when
// each skip phase starts.
// ----------------------------------------------------------------------------
module framed_page_extractor_unit import fpe_pkg::*; #(
  parameter int PAGE_BYTES = 52
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fpe_in_if.sink                in_ch,
  fpe_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BYTE_W-1:0] frame_index_r;
  logic              cfg_wr;
  cmd_t              cmd;
  stat_t             stat;

  // configuration register; the only register decodes the whole address range
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_index_r <= FRAME_INDEX_RST;
    end else if (cfg_wr) begin
      frame_index_r <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr == '0) ? CFG_DATA_W'(frame_index_r) : CFG_DATA_W'(frame_index_r);

  fpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpe_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rx_byte     (in_ch.rx_byte),
    .frame_index (frame_index_r),
    .stat        (stat),
    .page_byte   (out_ch.page_byte),
    .last_byte   (out_ch.last_byte)
  );

endmodule

### rtl/fpe_ram.sv
// ----------------------------------------------------------------------------
// fpe_ram
// Generic single-port RAM, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module fpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 52
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fpe_dp.sv
// ----------------------------------------------------------------------------
// fpe_dp
// Datapath: byte counter with skip-length multiplier, frame total, page
// store and the output register. Reports byte matches and counter status.
// ----------------------------------------------------------------------------
module fpe_dp import fpe_pkg::*; #(
  parameter int PAGE_BYTES = 52
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] frame_index,
  output stat_t             stat,
  output logic [BYTE_W-1:0] page_byte,
  output logic              last_byte
);

  localparam int ADDR_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam logic [COUNT_W-1:0] LAST_IDX = COUNT_W'(PAGE_BYTES - 1);

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0]  frame_total_r;
  logic [BYTE_W-1:0]  post_diff;
  logic [BYTE_W-1:0]  mul_a;
  logic [COUNT_W-1:0] mul_res;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [BYTE_W-1:0]  page_byte_r;
  logic               last_byte_r;

  // skip length: operand times page size (fits the counter for all frame indexes)
  assign post_diff = frame_total_r - frame_index - 8'd1;
  assign mul_a     = cmd.mul_post ? post_diff : frame_index;
  assign mul_res   = COUNT_W'(mul_a) * COUNT_W'(PAGE_BYTES);

  // byte counter
  always_comb begin
    unique case (cmd.count_op)
      CNT_HOLD:  byte_count_nxt = byte_count_r;
      CNT_CLEAR: byte_count_nxt = '0;
      CNT_LOAD:  byte_count_nxt = mul_res;
      CNT_DEC:   byte_count_nxt = byte_count_r - COUNT_W'(1);
      CNT_INC:   byte_count_nxt = byte_count_r + COUNT_W'(1);
      default:   byte_count_nxt = byte_count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      frame_total_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      if (cmd.load_total) begin
        frame_total_r <= rx_byte;
      end
    end
  end

  // page store, addressed by the counter for both capture and readout
  fpe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_page_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .re    (cmd.ram_re),
    .addr  (byte_count_r[ADDR_W-1:0]),
    .wdata (rx_byte),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      page_byte_r <= ram_rdata;
      last_byte_r <= (byte_count_r == LAST_IDX);
    end
  end

  assign page_byte = page_byte_r;
  assign last_byte = last_byte_r;

  // status to the controller; trailing skip only when frames remain after the selected one
  always_comb begin
    stat.is_m        = (rx_byte == CHR_M);
    stat.is_a        = (rx_byte == CHR_A);
    stat.is_g        = (rx_byte == CHR_G);
    stat.is_i        = (rx_byte == CHR_I);
    stat.is_nl       = (rx_byte == CHR_NL);
    stat.pre_nonzero = (frame_index != '0);
    stat.post_pos    = ({1'b0, frame_total_r} > ({1'b0, frame_index} + 9'd1));
    stat.count_one   = (byte_count_r == COUNT_W'(1));
    stat.count_last  = (byte_count_r == LAST_IDX);
  end

  // page writes stay inside the store
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_we |-> (byte_count_r < COUNT_W'(PAGE_BYTES)))
    else $error("page store write beyond page size");

endmodule

### rtl/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// fpe_ctrl
// Phase controller: header hunt, skip/capture sequencing, terminator check
// and the page readout loop.
// ----------------------------------------------------------------------------
module fpe_ctrl import fpe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  phase_t state_r, state_nxt;
  logic   in_fire;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_H0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r != PH_EMIT_RD) && (state_r != PH_EMIT_LD) &&
                     (state_r != PH_EMIT_OUT);
  assign out_valid = (state_r == PH_EMIT_OUT);
  assign in_fire   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.count_op   = CNT_HOLD;
    cmd.mul_post   = 1'b0;
    cmd.load_total = 1'b0;
    cmd.ram_we     = 1'b0;
    cmd.ram_re     = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state_r)
      PH_H1: if (in_fire) begin
        state_nxt = stat.is_a ? PH_H2 : PH_H0;
      end
      PH_H2: if (in_fire) begin
        state_nxt = stat.is_g ? PH_H3 : PH_H0;
      end
      PH_H3: if (in_fire) begin
        state_nxt = stat.is_i ? PH_TOTAL : PH_H0;
      end
      PH_TOTAL: if (in_fire) begin
        cmd.load_total = 1'b1;
        cmd.count_op   = CNT_LOAD;
        state_nxt      = stat.pre_nonzero ? PH_PRE : PH_CAP;
      end
      PH_PRE: if (in_fire) begin
        cmd.count_op = CNT_DEC;
        if (stat.count_one) begin
          state_nxt = PH_CAP;
        end
      end
      PH_CAP: if (in_fire) begin
        cmd.ram_we = 1'b1;
        // last page byte: set up the trailing skip, or go to the terminator if none
        if (stat.count_last) begin
          if (stat.post_pos) begin
            cmd.count_op = CNT_LOAD;
            cmd.mul_post = 1'b1;
            state_nxt    = PH_POST;
          end else begin
            cmd.count_op = CNT_CLEAR;
            state_nxt    = PH_TERM;
          end
        end else begin
          cmd.count_op = CNT_INC;
        end
      end
      PH_POST: if (in_fire) begin
        cmd.count_op = CNT_DEC;
        if (stat.count_one) begin
          state_nxt = PH_TERM;
        end
      end
      PH_TERM: if (in_fire) begin
        cmd.count_op = CNT_CLEAR;
        state_nxt    = stat.is_nl ? PH_EMIT_RD : PH_H0;
      end
      PH_EMIT_RD: begin
        cmd.ram_re = 1'b1;
        state_nxt  = PH_EMIT_LD;
      end
      PH_EMIT_LD: begin
        cmd.load_out = 1'b1;
        state_nxt    = PH_EMIT_OUT;
      end
      PH_EMIT_OUT: if (out_ready) begin
        if (stat.count_last) begin
          state_nxt = PH_H0;
        end else begin
          cmd.count_op = CNT_INC;
          state_nxt    = PH_EMIT_RD;
        end
      end
      default: if (in_fire) begin
        // hunting for the first header byte; unused codes land here too
        state_nxt = stat.is_m ? PH_H1 : PH_H0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a page item is presented");

  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_EMIT_LD) |-> ($past(state_r) == PH_EMIT_RD))
    else $error("output load without a preceding page read");

  a_last_ends_page: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_EMIT_OUT && out_ready && stat.count_last) |=> (state_r == PH_H0))
    else $error("readout did not return to hunting after the last item");

endmodule

### dv/framed_page_extractor_unit_tb.sv
// ----------------------------------------------------------------------------
// framed_page_extractor_unit_tb
// Self-checking bench for the framed page extractor. Byte streams with the
// Magi header, frame count, skipped frames, one captured page and the newline
// terminator are sent with random gaps. A byte-level predictor tracks the
// frame parser and queues the page bytes each accepted item should produce.
// Page bytes from the block are matched in order against that queue.
// A short table of directed frames covers the header and terminator corner
// cases and both skip directions; frame_index readback is checked at both
// extremes. Random frames then follow: mostly well formed, some with noise,
// broken headers or bad lengths.
// ----------------------------------------------------------------------------
module framed_page_extractor_unit_tb;
  import fpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BYTES   = 52;
  localparam int PG_AW        = $clog2(PAGE_BYTES);
  localparam int CLK_HALF     = 5;
  localparam int SETTLE       = 8;       // idle cycles before a register access
  localparam int TAIL         = 3 * PAGE_BYTES;
  localparam int RAND_ITEMS   = 50;
  localparam int LIMIT_CYCLES = 100000;
  localparam int MAX_SHOWN    = 10;
  localparam int DIR_N        = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_INDEX = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] page_byte;
    logic              last_byte;
  } page_item_t;

  // one directed frame: register setup, leading junk, header and framing
  typedef struct packed {
    int                pre_idx;    // frame_index written before, -1 keeps it
    int                mid_idx;    // written after the count byte, -1 none
    logic [31:0]       lead;       // junk bytes ahead of the header
    int                lead_n;
    logic [31:0]       hdr;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] term;
    bit                burst;
    bit                want_page;
  } frame_row_t;

  localparam frame_row_t DIR_ROWS [DIR_N] = '{
    // reset frame_index of 1 skips one frame; count one past it: no trailing skip
    '{-1,  -1, 32'h0, 0, "Magi",   8'd2, CHR_NL, 1'b0, 1'b1},
    // broken header ending in M, then a clean one; one trailing frame skipped
    '{ 0,  -1, "MagM", 4, "Magi",  8'd2, CHR_NL, 1'b1, 1'b1},
    // wrong terminator
    '{-1,  -1, 32'h0, 0, "Magi",   8'd1, CHR_M,  1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fpe_in_if  in_ch ();
  fpe_out_if out_ch ();

  framed_page_extractor_unit #(.PAGE_BYTES(PAGE_BYTES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // frame parser shadow state
  logic [BYTE_W-1:0]  sel_frame;
  phase_t             fr_phase;
  logic [COUNT_W-1:0] fr_count;
  logic [BYTE_W-1:0]  fr_total;
  logic [BYTE_W-1:0]  page_img [PAGE_BYTES];

  page_item_t page_q [$];

  int  errors;
  int  bytes_sent;
  int  bytes_checked;
  int  pages_done;
  int  cfg_writes;
  int  sink_hold;
  int  cycles;
  bit  in_fast;
  bit  out_fast;

  function automatic void report_miss(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // advance the parser by one accepted byte, queue the page on a good newline
  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    int         span;
    int         k;
    page_item_t item;
    case (fr_phase)
      PH_H1: fr_phase = (b == CHR_A) ? PH_H2 : PH_H0;
      PH_H2: fr_phase = (b == CHR_G) ? PH_H3 : PH_H0;
      PH_H3: fr_phase = (b == CHR_I) ? PH_TOTAL : PH_H0;
      PH_TOTAL: begin
        fr_total = b;
        fr_count = COUNT_W'(int'(sel_frame) * PAGE_BYTES);
        fr_phase = (fr_count != '0) ? PH_PRE : PH_CAP;
      end
      PH_PRE: begin
        fr_count = fr_count - COUNT_W'(1);
        if (fr_count == '0) fr_phase = PH_CAP;
      end
      PH_CAP: begin
        if (fr_count < COUNT_W'(PAGE_BYTES)) page_img[fr_count[PG_AW-1:0]] = b;
        fr_count = fr_count + COUNT_W'(1);
        if (fr_count >= COUNT_W'(PAGE_BYTES)) begin
          // trailing skip only when frames remain after the selected one
          span = int'(fr_total) - int'(sel_frame) - 1;
          if (span > 0) begin
            fr_count = COUNT_W'(span * PAGE_BYTES);
            fr_phase = (fr_count != '0) ? PH_POST : PH_TERM;
          end else begin
            fr_count = '0;
            fr_phase = PH_TERM;
          end
        end
      end
      PH_POST: begin
        fr_count = fr_count - COUNT_W'(1);
        if (fr_count == '0) fr_phase = PH_TERM;
      end
      PH_TERM: begin
        if (b == CHR_NL) begin
          for (k = 0; k < PAGE_BYTES; k++) begin
            item.page_byte = page_img[PG_AW'(k)];
            item.last_byte = (k == PAGE_BYTES - 1);
            page_q.push_back(item);
          end
        end
        fr_count = '0;
        fr_phase = PH_H0;
      end
      default: fr_phase = (b == CHR_M) ? PH_H1 : PH_H0;
    endcase
  endfunction

  function automatic void check_page_byte(input logic [BYTE_W-1:0] pb, input logic lb);
    page_item_t want;
    if (page_q.size() == 0) begin
      report_miss($sformatf("page_byte %02h last %0b with nothing pending", pb, lb));
      return;
    end
    want = page_q.pop_front();
    bytes_checked++;
    if (pb !== want.page_byte) begin
      report_miss($sformatf("page_byte expected %02h, got %02h", want.page_byte, pb));
    end
    if (lb !== want.last_byte) begin
      report_miss($sformatf("last_byte expected %0b, got %0b", want.last_byte, lb));
    end
    if (lb === 1'b1) pages_done++;
  endfunction

  // directed body: page edges hold 00 and FF, the rest a stride pattern
  function automatic logic [BYTE_W-1:0] dir_byte(input int k, input int tag);
    int ofs;
    ofs = k % PAGE_BYTES;
    if (ofs == 0) return 8'h00;
    if (ofs == PAGE_BYTES - 1) return 8'hFF;
    return BYTE_W'(k * 37 + tag);
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CHR_M;
      1: return CHR_A;
      2: return CHR_G;
      3: return CHR_I;
      4: return CHR_NL;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // result sink: random stall after every item (none in fast mode), checked in order
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_page_byte(out_ch.page_byte, out_ch.last_byte);
        sink_hold = out_fast ? 0 : $urandom_range(0, 11);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_ch.ready <= (sink_hold == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d page bytes still pending",
               cycles, page_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // send one item; valid stays high across back-to-back items
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    track_byte(b);
    bytes_sent++;
  endtask

  // stop input and let every pending page drain before touching registers
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (page_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_FRAME_INDEX;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write frame_index (junk in the upper bits) and read it back
  task automatic write_frame_index(input logic [BYTE_W-1:0] v);
    logic [CFG_DATA_W-1:0] rd;
    wait_quiet();
    apb_xfer(1'b1, {(CFG_DATA_W-BYTE_W)'($urandom), v}, rd);
    sel_frame = v;
    cfg_writes++;
    @(posedge clk);
    apb_xfer(1'b0, '0, rd);
    if (rd[BYTE_W-1:0] !== v) begin
      report_miss($sformatf("frame_index readback expected %02h, got %02h",
                            v, rd[BYTE_W-1:0]));
    end
  endtask

  // header, count, body sized for the current index, terminator
  task automatic send_frame(input logic [31:0] hdr, input logic [BYTE_W-1:0] total,
                            input int mid_idx, input int body_adj,
                            input logic [BYTE_W-1:0] term, input int tag, input bit rnd);
    int pre_sel;
    int span;
    int body_n;
    int i;
    for (i = 3; i >= 0; i--) push_byte(hdr[8*i +: 8]);
    pre_sel = sel_frame;
    push_byte(total);
    if (mid_idx >= 0) write_frame_index(BYTE_W'(mid_idx));
    span   = int'(total) - int'(sel_frame) - 1;
    body_n = (pre_sel + 1) * PAGE_BYTES + ((span > 0) ? span * PAGE_BYTES : 0) + body_adj;
    for (i = 0; i < body_n; i++) begin
      push_byte(rnd ? BYTE_W'($urandom) : dir_byte(i, tag));
    end
    push_byte(term);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    logic [31:0]           hdr;
    logic [BYTE_W-1:0]     term;
    int                    p0;
    int                    r;
    int                    i;
    int                    rand_start;
    int                    mid;
    int                    adj;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    bytes_sent    = 0;
    bytes_checked = 0;
    pages_done    = 0;
    cfg_writes    = 0;
    cycles        = 0;
    in_fast       = 1'b0;
    out_fast      = 1'b0;
    sel_frame     = FRAME_INDEX_RST;
    fr_phase      = PH_H0;
    fr_count      = '0;
    fr_total      = '0;
    for (i = 0; i < PAGE_BYTES; i++) page_img[PG_AW'(i)] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the register
    apb_xfer(1'b0, '0, rd);
    if (rd[BYTE_W-1:0] !== FRAME_INDEX_RST) begin
      report_miss($sformatf("frame_index after reset expected %02h, got %02h",
                            FRAME_INDEX_RST, rd[BYTE_W-1:0]));
    end
    @(posedge clk);

    // directed frames
    for (r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].pre_idx >= 0) write_frame_index(BYTE_W'(DIR_ROWS[r].pre_idx));
      in_fast = DIR_ROWS[r].burst;
      p0 = pages_done;
      for (i = DIR_ROWS[r].lead_n - 1; i >= 0; i--) push_byte(DIR_ROWS[r].lead[8*i +: 8]);
      send_frame(DIR_ROWS[r].hdr, DIR_ROWS[r].total, DIR_ROWS[r].mid_idx, 0,
                 DIR_ROWS[r].term, r, 1'b0);
      wait_quiet();
      if ((pages_done - p0) != int'(DIR_ROWS[r].want_page)) begin
        report_miss($sformatf("directed frame %0d: expected %0d pages, got %0d",
                              r, DIR_ROWS[r].want_page, pages_done - p0));
      end
    end
    in_fast = 1'b0;

    // register extremes, read back only
    write_frame_index(8'hFF);
    write_frame_index(8'h00);

    // random frames: mostly clean, some noise, broken headers, bad lengths
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_ITEMS) begin
      in_fast  = ($urandom_range(0, 4) == 0);
      out_fast = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) write_frame_index(BYTE_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) push_byte(noise_byte());
      end
      hdr = "Magi";
      if ($urandom_range(0, 9) == 0) hdr[8*$urandom_range(0, 3) +: 8] = noise_byte();
      mid  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : -1;
      adj  = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 1 : -1) : 0;
      term = ($urandom_range(0, 9) == 0) ? noise_byte() : CHR_NL;
      send_frame(hdr, BYTE_W'($urandom_range(0, 3)), mid, adj, term, 0, 1'b1);
    end

    // drain
    in_ch.valid <= 1'b0;
    while (page_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (page_q.size() != 0) begin
      report_miss($sformatf("%0d page bytes never arrived", page_q.size()));
    end

    $display("run covered %0d received items, %0d frame_index writes",
             bytes_sent, cfg_writes);
    $display("%0d page bytes checked in %0d pages, %0d mismatches",
             bytes_checked, pages_done, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fpe_pkg.sv
rtl/fpe_if.sv
rtl/fpe_ram.sv
rtl/fpe_dp.sv
rtl/fpe_ctrl.sv
rtl/framed_page_extractor_unit.sv
dv/framed_page_extractor_unit_tb.sv
